@@ design/knx_transport_connection_fsm_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef KNX_TRANSPORT_CONNECTION_FSM_DEFINES_SVH
`define KNX_TRANSPORT_CONNECTION_FSM_DEFINES_SVH

// A clocked property that is ignored while reset is high.
`define KNXTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must hold whenever a result is offered.
`define KNXTC_ASSERT_OUT(lbl, expr, msg) \
  `KNXTC_ASSERT(lbl, out_valid |-> (expr), msg)

`endif

@@ design/knxtc_pkg.sv @@
`default_nettype none
package knxtc_pkg;

  localparam int unsigned TIMER_BITS = 16;
  localparam int unsigned CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  localparam logic [1:0] REG_OWN_ADDRESS = 2'd0;
  localparam logic [1:0] REG_ENABLE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic [15:0] OWN_ADDRESS_RESET = 16'd0;
  localparam logic ENABLE_RESET = 1'b1;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd6000;

  localparam logic [7:0] CTRL_CONNECT = 8'h80;
  localparam logic [7:0] CTRL_DISCONNECT = 8'h81;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ACK = 2'd1;
  localparam logic [1:0] KIND_DISC = 2'd2;
  localparam logic [1:0] KIND_DATA = 2'd3;

  localparam logic [1:0] LINK_CLOSED = 2'd0;
  localparam logic [1:0] LINK_IDLE = 2'd1;
  localparam logic [1:0] LINK_WAIT = 2'd2;

  typedef struct packed {
    logic        func;
    logic [15:0] source_address;
    logic [15:0] dest_address;
    logic        group_flag;
    logic [7:0]  ctrl_byte;
    logic [1:0]  priority_req;
    logic        respond;
    logic        bus_idle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [15:0] send_dest;
    logic [3:0]  send_seq;
    logic [1:0]  send_priority;
    logic        deliver;
    logic [1:0]  link_state;
    logic [15:0] disconnect_total;
  } out_item_t;

  typedef struct packed {
    logic [15:0] own_address;
    logic        enable;
    logic [15:0] timeout_ticks;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    CLS_DROP,
    CLS_CONNECT,
    CLS_DISCONNECT,
    CLS_ACK,
    CLS_DATA,
    CLS_TICK
  } event_cls_t;

  typedef struct packed {
    event_cls_t  cls;
    logic [15:0] src;
    logic [3:0]  seq;
    logic        nack;
    logic [1:0]  prio;
    logic        respond;
    logic        bus_idle;
  } event_t;

endpackage
`default_nettype wire

@@ design/knxtc_front.sv @@
`default_nettype none
module knxtc_front
  import knxtc_pkg::*;
(
  input  wire cfg_regs_t cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           push,
  output event_t         push_data,
  input  wire logic      queue_full
);

  logic for_us;
  logic rx_accepted;

  assign in_ready = !queue_full;
  assign rx_accepted = in_valid && in_ready;
  assign push = rx_accepted;
  assign for_us = !in_data.group_flag && (in_data.dest_address == cfg.own_address);

  always_comb begin
    push_data.src = in_data.source_address;
    push_data.seq = in_data.ctrl_byte[5:2];
    push_data.nack = in_data.ctrl_byte[0];
    push_data.prio = in_data.priority_req;
    push_data.respond = in_data.respond;
    push_data.bus_idle = in_data.bus_idle;
    if (in_data.func) begin
      push_data.cls = CLS_TICK;
    end else if (!for_us) begin
      push_data.cls = CLS_DROP;
    end else if (!in_data.ctrl_byte[7]) begin
      push_data.cls = CLS_DATA;
    end else if (in_data.ctrl_byte == CTRL_CONNECT) begin
      push_data.cls = CLS_CONNECT;
    end else if (in_data.ctrl_byte == CTRL_DISCONNECT) begin
      push_data.cls = CLS_DISCONNECT;
    end else if (in_data.ctrl_byte[1]) begin
      push_data.cls = CLS_ACK;
    end else begin
      // Control octets with no known meaning are ignored like foreign traffic.
      push_data.cls = CLS_DROP;
    end
  end

endmodule
`default_nettype wire

@@ design/knxtc_queue.sv @@
`default_nettype none
module knxtc_queue
  import knxtc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire event_t push_data,
  output logic        full,
  output logic        pop_valid,
  input  wire logic   pop_ready,
  output event_t      pop_data
);

  event_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/knxtc_back.sv @@
`default_nettype none
module knxtc_back
  import knxtc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_regs_t cfg,
  input  wire logic      ev_valid,
  output logic           ev_ready,
  input  wire event_t    ev,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  typedef enum logic [1:0] {
    ST_CLOSED = LINK_CLOSED,
    ST_IDLE = LINK_IDLE,
    ST_WAIT = LINK_WAIT
  } link_st_t;

  link_st_t              state, state_next;
  logic [15:0]           partner, partner_next;
  logic [3:0]            sseq, sseq_next;
  logic [3:0]            rseq, rseq_next;
  logic [TIMER_BITS-1:0] timer, timer_next, timer_inc;
  logic                  pending, pending_next;
  logic [1:0]            rprio, rprio_next;
  logic [15:0]           disc_cnt, disc_cnt_next;
  out_item_t             res_next;
  logic                  link_open;
  logic                  from_partner;
  logic                  take;

  assign ev_ready = !out_valid || out_ready;
  assign take = ev_valid && ev_ready;
  assign link_open = (state != ST_CLOSED);
  assign from_partner = (ev.src == partner);
  assign timer_inc = (timer == {TIMER_BITS{1'b1}}) ? timer : timer + 1'b1;

  always_comb begin
    state_next = state;
    partner_next = partner;
    sseq_next = sseq;
    rseq_next = rseq;
    timer_next = timer;
    pending_next = pending;
    rprio_next = rprio;
    disc_cnt_next = disc_cnt;
    res_next = '0;
    res_next.send_kind = KIND_NONE;

    unique case (ev.cls)
      CLS_CONNECT: begin
        if (!link_open) begin
          pending_next = 1'b0;
          partner_next = ev.src;
          sseq_next = 4'd0;
          rseq_next = 4'd0;
          timer_next = '0;
          state_next = ST_IDLE;
        end else begin
          disc_cnt_next = disc_cnt + 16'd1;
          res_next.send_kind = KIND_DISC;
          if (from_partner) begin
            state_next = ST_CLOSED;
            res_next.send_dest = partner;
          end else begin
            res_next.send_dest = ev.src;
          end
        end
      end
      CLS_DISCONNECT: begin
        if (link_open && from_partner) begin
          state_next = ST_CLOSED;
          disc_cnt_next = disc_cnt + 16'd1;
        end
      end
      CLS_ACK: begin
        if (!link_open || !from_partner) begin
          disc_cnt_next = disc_cnt + 16'd1;
          res_next.send_kind = KIND_DISC;
          res_next.send_dest = ev.src;
        end else if (!ev.nack && ev.seq == sseq && state == ST_WAIT) begin
          sseq_next = sseq + 4'd1;
          timer_next = '0;
          state_next = ST_IDLE;
        end else begin
          disc_cnt_next = disc_cnt + 16'd1;
          state_next = ST_CLOSED;
          res_next.send_kind = KIND_DISC;
          res_next.send_dest = partner;
        end
      end
      CLS_DATA: begin
        if (!link_open || !from_partner) begin
          disc_cnt_next = disc_cnt + 16'd1;
          res_next.send_kind = KIND_DISC;
          res_next.send_dest = ev.src;
        end else if (ev.seq == rseq) begin
          res_next.deliver = 1'b1;
          res_next.send_kind = KIND_ACK;
          res_next.send_dest = partner;
          res_next.send_seq = ev.seq;
          rseq_next = rseq + 4'd1;
          timer_next = '0;
          pending_next = ev.respond;
          if (ev.respond) begin
            rprio_next = ev.prio;
          end
        end else if (ev.seq == rseq - 4'd1) begin
          // A repeat of the last telegram is acknowledged again.
          res_next.send_kind = KIND_ACK;
          res_next.send_dest = partner;
          res_next.send_seq = ev.seq;
          timer_next = '0;
        end else begin
          disc_cnt_next = disc_cnt + 16'd1;
          state_next = ST_CLOSED;
          res_next.send_kind = KIND_DISC;
          res_next.send_dest = partner;
        end
      end
      CLS_TICK: begin
        timer_next = timer_inc;
        if (cfg.enable) begin
          if (link_open && CMP_W'(timer_inc) >= CMP_W'(cfg.timeout_ticks)) begin
            disc_cnt_next = disc_cnt + 16'd1;
            state_next = ST_CLOSED;
            res_next.send_kind = KIND_DISC;
            res_next.send_dest = partner;
          end
          // A timeout on this tick closes the link, which holds back the response.
          if (pending && ev.bus_idle && state_next != ST_CLOSED) begin
            res_next.send_kind = KIND_DATA;
            res_next.send_dest = partner;
            res_next.send_seq = sseq;
            res_next.send_priority = rprio;
            state_next = ST_WAIT;
            pending_next = 1'b0;
            timer_next = '0;
          end
        end
      end
      default: begin
      end
    endcase

    res_next.link_state = state_next;
    res_next.disconnect_total = disc_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLOSED;
      partner <= '0;
      sseq <= '0;
      rseq <= '0;
      timer <= '0;
      pending <= 1'b0;
      rprio <= '0;
      disc_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        state <= state_next;
        partner <= partner_next;
        sseq <= sseq_next;
        rseq <= rseq_next;
        timer <= timer_next;
        pending <= pending_next;
        rprio <= rprio_next;
        disc_cnt <= disc_cnt_next;
        out_data <= res_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/knx_transport_connection_fsm.sv @@
// Channel   Handshake              Payload              Direction
// in        in_valid/in_ready      in_item_t in_data    telegram or tick, into the block
// out       out_valid/out_ready    out_item_t out_data  one result per input transfer
// cfg       cfg_valid/cfg_ready    cfg_index, cfg_data  register write, always ready
//
// One item per cycle sustained while out_ready stays high; an input waits in the two-entry
// event queue, and its result is registered in the back end's output register and can then
// transfer out. The back end's state update on each accepted event sets the rate.
// Reset is synchronous and active high; registers return to their reset values.
// An output stall backs up the queue; input ready drops only when the queue is full.
`default_nettype none
module knx_transport_connection_fsm
  import knxtc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_regs_t cfg;
  logic      push;
  event_t    push_data;
  logic      queue_full;
  logic      ev_valid;
  logic      ev_ready;
  event_t    ev;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address <= OWN_ADDRESS_RESET;
      cfg.enable <= ENABLE_RESET;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OWN_ADDRESS: cfg.own_address <= cfg_data;
        REG_ENABLE: cfg.enable <= cfg_data[0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  knxtc_front u_front (
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  knxtc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop_valid (ev_valid),
    .pop_ready (ev_ready),
    .pop_data  (ev)
  );

  knxtc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ev_valid  (ev_valid),
    .ev_ready  (ev_ready),
    .ev        (ev),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ design/knxtc_checker.sv @@
`default_nettype none
`include "knx_transport_connection_fsm_defines.svh"
module knxtc_checker
  import knxtc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  `KNXTC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
  `KNXTC_ASSERT_OUT(a_none_clean, out_data.send_kind != KIND_NONE || (out_data.send_dest == 16'd0 && out_data.send_seq == 4'd0 && out_data.send_priority == 2'd0), "empty send carries fields")
  `KNXTC_ASSERT_OUT(a_deliver_ack, !out_data.deliver || (out_data.send_kind == KIND_ACK && out_data.link_state != LINK_CLOSED), "delivery without ack on open link")
  `KNXTC_ASSERT_OUT(a_data_wait, out_data.send_kind != KIND_DATA || out_data.link_state == LINK_WAIT, "data response without waiting state")
  `KNXTC_ASSERT_OUT(a_state_code, out_data.link_state != 2'd3, "link state out of range")

endmodule

bind knx_transport_connection_fsm knxtc_checker u_checker (.*);
`default_nettype wire
